FILE: rtl/urb_pkg.sv
// shared types and constants for the uart ring buffer block
// used by urb_ram, urb_ctrl and uart_ring_buffers_with_delimiter; no dependencies
package urb_pkg;

	localparam int RX_DEPTH_DEF = 16;
	localparam int TX_DEPTH_DEF = 16;

	// command codes
	localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
	localparam logic [2:0] CMD_TX_FREE  = 3'd1;
	localparam logic [2:0] CMD_TX_WRITE = 3'd2;
	localparam logic [2:0] CMD_RX_READ  = 3'd3;
	localparam logic [2:0] CMD_RX_PEEK  = 3'd4;
	localparam logic [2:0] CMD_LINE_LEN = 3'd5;

	// sticky status bits, and the no-data read status
	localparam logic [4:0] STK_AVAIL   = 5'b00001;
	localparam logic [4:0] STK_BUFOVF  = 5'b00010;
	localparam logic [4:0] STK_OVERRUN = 5'b00100;
	localparam logic [4:0] STK_FRAME   = 5'b01000;
	localparam logic [4:0] STK_PARITY  = 5'b10000;
	localparam logic [5:0] STAT_NODATA = 6'b100000;

	localparam logic [3:0] LEN_MAX = 4'd15;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       overrun_flag;
		logic       frame_flag;
		logic       parity_flag;
	} urb_cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic [5:0] read_flags;
		logic [5:0] rx_status;
		logic       tx_full;
		logic       tx_send;
		logic       tx_irq_enable;
		logic       accepted;
		logic [3:0] line_length;
		logic       delimiter_pending;
	} urb_result_t;

endpackage

FILE: rtl/urb_ram.sv
// byte-wide ring buffer storage: one write port, one registered read port
// depends on urb_pkg only for the RX_DEPTH_DEF default of DEPTH
module urb_ram import urb_pkg::*; #(
	parameter int DEPTH = RX_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/urb_ctrl.sv
// sequencer for the rx and tx ring buffers: pointers, sticky status, delimiter scan
// depends on urb_pkg; drives two urb_ram instances held by the top level
module urb_ctrl import urb_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	localparam int RX_AW = $clog2(RX_DEPTH),
	localparam int TX_AW = $clog2(TX_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  urb_cmd_t         cmd,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	output logic             res_valid,
	input  logic             res_ready,
	output urb_result_t      res,
	output logic             rx_we,
	output logic [RX_AW-1:0] rx_waddr,
	output logic [7:0]       rx_wdata,
	output logic             rx_re,
	output logic [RX_AW-1:0] rx_raddr,
	input  logic [7:0]       rx_rdata,
	output logic             tx_we,
	output logic [TX_AW-1:0] tx_waddr,
	output logic [7:0]       tx_wdata,
	output logic             tx_re,
	output logic [TX_AW-1:0] tx_raddr,
	input  logic [7:0]       tx_rdata
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_RD        = 3'd1;
	localparam logic [2:0] ST_SCAN_ADDR = 3'd2;
	localparam logic [2:0] ST_SCAN_CMP  = 3'd3;
	localparam logic [2:0] ST_RESP      = 3'd4;

	function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
	endfunction

	function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
	endfunction

	logic [2:0]       state_q;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q, pos_q;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [4:0]       sticky_q;
	logic             mark_q, tx_req_q;
	logic [7:0]       search_q;
	logic [3:0]       cnt_q;
	logic             rd_tx_q;

	// per-item result fields
	logic [7:0] rd_q;
	logic       rvalid_q, send_q, acc_q;
	logic [5:0] rflags_q;
	logic [3:0] len_q;

	logic             fire, rx_empty, rx_full, tx_empty, tx_full, is_delim;
	logic [RX_AW-1:0] rx_head_nx, rx_tail_nx;
	logic [TX_AW-1:0] tx_head_nx, tx_tail_nx;
	logic [4:0]       errs;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign fire       = cmd_valid && cmd_ready;
	assign rx_head_nx = rx_inc(rx_head_q);
	assign rx_tail_nx = rx_inc(rx_tail_q);
	assign tx_head_nx = tx_inc(tx_head_q);
	assign tx_tail_nx = tx_inc(tx_tail_q);
	assign rx_empty   = (rx_head_q == rx_tail_q);
	assign rx_full    = (rx_head_nx == rx_tail_q);
	assign tx_empty   = (tx_head_q == tx_tail_q);
	assign tx_full    = (tx_head_nx == tx_tail_q);
	assign is_delim   = (search_q != 8'd0) && (search_q == cmd.data_byte);
	assign errs       = (cmd.overrun_flag ? STK_OVERRUN : 5'd0)
		| (cmd.frame_flag ? STK_FRAME : 5'd0)
		| (cmd.parity_flag ? STK_PARITY : 5'd0);

	assign rx_we    = fire && (cmd.command == CMD_RX_BYTE) && !rx_full;
	assign rx_waddr = rx_head_nx;
	assign rx_wdata = cmd.data_byte;
	assign rx_re    = (fire && !rx_empty
		&& (cmd.command == CMD_RX_READ || cmd.command == CMD_RX_PEEK))
		|| (state_q == ST_SCAN_ADDR && pos_q != rx_head_q);
	assign rx_raddr = (state_q == ST_SCAN_ADDR) ? rx_inc(pos_q) : rx_tail_nx;

	assign tx_we    = fire && (cmd.command == CMD_TX_WRITE) && !tx_full;
	assign tx_waddr = tx_head_nx;
	assign tx_wdata = cmd.data_byte;
	assign tx_re    = fire && (cmd.command == CMD_TX_FREE) && !tx_empty;
	assign tx_raddr = tx_tail_nx;

	// result is built from the state after the step
	assign res_valid = (state_q == ST_RESP);
	always_comb begin
		res.read_data         = rd_q;
		res.read_valid        = rvalid_q;
		res.read_flags        = rflags_q;
		res.rx_status         = {rx_empty, sticky_q};
		res.tx_full           = tx_full;
		res.tx_send           = send_q;
		res.tx_irq_enable     = tx_req_q;
		res.accepted          = acc_q;
		res.line_length       = len_q;
		res.delimiter_pending = mark_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			pos_q     <= '0;
			sticky_q  <= '0;
			mark_q    <= 1'b0;
			tx_req_q  <= 1'b0;
			search_q  <= '0;
			cnt_q     <= '0;
			rd_tx_q   <= 1'b0;
			rd_q      <= '0;
			rvalid_q  <= 1'b0;
			send_q    <= 1'b0;
			acc_q     <= 1'b0;
			rflags_q  <= '0;
			len_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						rd_q     <= '0;
						rvalid_q <= 1'b0;
						send_q   <= 1'b0;
						acc_q    <= 1'b0;
						rflags_q <= '0;
						len_q    <= '0;
						state_q  <= ST_RESP;
						unique case (cmd.command)
							CMD_RX_BYTE: begin
								if (rx_full) begin
									sticky_q <= sticky_q | errs | STK_BUFOVF;
								end else begin
									sticky_q  <= sticky_q | errs | STK_AVAIL;
									rx_head_q <= rx_head_nx;
									acc_q     <= 1'b1;
									if (is_delim) begin
										mark_q <= 1'b1;
									end
								end
							end
							CMD_TX_FREE: begin
								if (!tx_empty) begin
									tx_tail_q <= tx_tail_nx;
									rd_tx_q   <= 1'b1;
									state_q   <= ST_RD;
								end else begin
									tx_req_q <= 1'b0;
								end
							end
							CMD_TX_WRITE: begin
								if (!tx_full) begin
									tx_head_q <= tx_head_nx;
									tx_req_q  <= 1'b1;
									acc_q     <= 1'b1;
								end
							end
							CMD_RX_READ, CMD_RX_PEEK: begin
								if (rx_empty) begin
									rflags_q <= STAT_NODATA;
								end else begin
									rflags_q <= {1'b0, sticky_q};
									rd_tx_q  <= 1'b0;
									state_q  <= ST_RD;
									if (cmd.command == CMD_RX_READ) begin
										rx_tail_q <= rx_tail_nx;
										mark_q    <= 1'b0;
										sticky_q  <= STK_AVAIL;
									end
								end
							end
							CMD_LINE_LEN: begin
								if (mark_q) begin
									pos_q   <= rx_tail_q;
									cnt_q   <= '0;
									state_q <= ST_SCAN_ADDR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					rd_q     <= rd_tx_q ? tx_rdata : rx_rdata;
					rvalid_q <= 1'b1;
					send_q   <= rd_tx_q;
					state_q  <= ST_RESP;
				end
				ST_SCAN_ADDR: begin
					// reached the newest byte without a delimiter
					if (pos_q == rx_head_q) begin
						mark_q  <= 1'b0;
						state_q <= ST_RESP;
					end else begin
						pos_q   <= rx_inc(pos_q);
						cnt_q   <= (cnt_q == LEN_MAX) ? cnt_q : cnt_q + 4'd1;
						state_q <= ST_SCAN_CMP;
					end
				end
				ST_SCAN_CMP: begin
					if (rx_rdata == search_q) begin
						len_q   <= cnt_q;
						mark_q  <= 1'b0;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_SCAN_ADDR;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				search_q <= cfg_wr_data;
				mark_q   <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/uart_ring_buffers_with_delimiter.sv
// top level of the uart rx/tx ring buffers with delimiter search
// depends on urb_pkg, urb_ram and urb_ctrl
//
// Usage: each beat on the s_axis side is one command (tuser) with its byte and
// receive error flags (tdata). Each command gives exactly one result beat on the
// m_axis side: read or popped byte, read status, sticky rx status, tx flags and
// the line length of a delimiter query. cfg_wr_en/cfg_wr_data set the delimiter
// character (0 disables) and clear the pending mark; write only while idle.
// Sequencing: rx byte, tx write, empty read and query without mark go from idle
// straight to the result state; a read, peek or tx pop first passes the read
// state for the registered read of the buffer memory. A line query with a pending
// mark walks the rx memory one entry per address and compare state pair, until
// the delimiter matches or the newest byte is reached without one.
// A new command is taken once the previous result is in the output register, so
// the sequencer does not take a new command before it is through with the last.
// Reset empties both buffers and clears status, mark, tx request and delimiter;
// memory contents are left as they are. While m_axis_tready is low the result
// waits in the output register; one more command may be accepted and then the
// sequencer holds until the register frees.
module uart_ring_buffers_with_delimiter import urb_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte, overrun_flag, frame_flag, parity_flag
	input  logic [2:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data, read_flags, rx_status, tx_full, tx_send, tx_irq_enable, accepted,
	// line_length, delimiter_pending
	output logic [31:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser,  // read_valid
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	urb_cmd_t    cmd;
	urb_result_t res, out_q;
	logic        res_valid, res_ready, out_valid_q;

	logic             rx_we, rx_re, tx_we, tx_re;
	logic [RX_AW-1:0] rx_waddr, rx_raddr;
	logic [TX_AW-1:0] tx_waddr, tx_raddr;
	logic [7:0]       rx_wdata, rx_rdata, tx_wdata, tx_rdata;

	always_comb begin
		cmd.command      = s_axis_tuser;
		cmd.data_byte    = s_axis_tdata[7:0];
		cmd.overrun_flag = s_axis_tdata[8];
		cmd.frame_flag   = s_axis_tdata[9];
		cmd.parity_flag  = s_axis_tdata[10];
	end

	urb_ctrl #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (s_axis_tvalid),
		.cmd_ready  (s_axis_tready),
		.cmd        (cmd),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.rx_we      (rx_we),
		.rx_waddr   (rx_waddr),
		.rx_wdata   (rx_wdata),
		.rx_re      (rx_re),
		.rx_raddr   (rx_raddr),
		.rx_rdata   (rx_rdata),
		.tx_we      (tx_we),
		.tx_waddr   (tx_waddr),
		.tx_wdata   (tx_wdata),
		.tx_re      (tx_re),
		.tx_raddr   (tx_raddr),
		.tx_rdata   (tx_rdata)
	);

	urb_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(rx_wdata),
		.re   (rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	urb_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(tx_wdata),
		.re   (tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	// output register parts the sequencer from the downstream stall
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.read_valid;
	assign m_axis_tdata  = {3'b000, out_q.delimiter_pending, out_q.line_length,
		out_q.accepted, out_q.tx_irq_enable, out_q.tx_send, out_q.tx_full,
		out_q.rx_status, out_q.read_flags, out_q.read_data};

endmodule
